### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/grc_pkg.sv
// Package with the types, constants and helper functions of the ray-cast classifier.
package grc_pkg;

    localparam int GRID_DIM = 64;
    localparam int COORD_W  = $clog2(GRID_DIM);
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int DIM_W    = 7;
    localparam int POS_W    = 8;
    localparam int TERM_W   = 11;
    localparam int COST_W   = 8;
    localparam int CFG_W    = 8;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_LETHAL_COST = 2'd2;

    localparam logic [1:0] CLASS_FREE     = 2'd0;
    localparam logic [1:0] CLASS_OCCUPIED = 2'd1;
    localparam logic [1:0] CLASS_UNKNOWN  = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [TERM_W-1:0] f;
    } t_walk;

    typedef struct packed {
        logic signed [TERM_W-1:0] d1;
        logic signed [TERM_W-1:0] d2;
        logic signed [POS_W-1:0]  ix;
        logic signed [POS_W-1:0]  iy;
        logic                     x_major;
    } t_geom;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(GRID_DIM);
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic inside_grid(input logic signed [POS_W-1:0] x,
                                         input logic signed [POS_W-1:0] y,
                                         input logic [DIM_W-1:0] w,
                                         input logic [DIM_W-1:0] h);
        logic signed [POS_W-1:0] ws;
        logic signed [POS_W-1:0] hs;
        ws = $signed(POS_W'(w));
        hs = $signed(POS_W'(h));
        return !x[POS_W-1] && !y[POS_W-1] && (x < ws) && (y < hs);
    endfunction

endpackage

### rtl/grid_ray_cast_classifier_top.sv
// Top level of the grid ray-cast classifier: map store, walk sequencer and result register.
//
// A load item is taken while idle and busy never rises for it. A trace item whose start lies
// inside the grid keeps busy high while the start cell is fetched and its cells are walked:
// the S_FETCH state reads the start cell from the map RAM, then in S_WALK each cycle the
// shared step unit advances one cell while the RAM reads it. Each cell's class is
// registered and shown on the result ports for one cycle under o_valid; the receiver cannot
// stall results. A trace that starts outside the grid reports nothing and leaves busy low.
`include "assert_macros.svh"
module grid_ray_cast_classifier_top import grc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_kind,
    input  logic [COORD_W-1:0]      i_cell_x,
    input  logic [COORD_W-1:0]      i_cell_y,
    input  logic [COST_W-1:0]       i_cell_cost,
    input  logic signed [POS_W-1:0] i_start_x,
    input  logic signed [POS_W-1:0] i_start_y,
    input  logic signed [POS_W-1:0] i_target_x,
    input  logic signed [POS_W-1:0] i_target_y,
    output logic                    o_valid,
    output logic [COORD_W-1:0]      o_out_x,
    output logic [COORD_W-1:0]      o_out_y,
    output logic [1:0]              o_cell_class,
    output logic                    o_is_last
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_WALK  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [DIM_W-1:0]   r_grid_w, r_grid_h;
    logic [COST_W-1:0]  r_lethal;
    t_walk              r_walk, n_walk;
    t_geom              r_geom, n_geom;
    logic               r_single, n_single;
    logic               r_seen, n_seen;
    logic               r_valid, n_valid;
    logic [COORD_W-1:0] r_out_x, n_out_x;
    logic [COORD_W-1:0] r_out_y, n_out_y;
    logic [1:0]         r_class, n_class;
    logic               r_last, n_last;

    logic               accept;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic               ram_rdata;
    logic [DIM_W-1:0]   w_eff, h_eff;
    t_walk              step_next;
    logic               step_inside;

    logic signed [POS_W:0]  dx, dy;
    logic [POS_W-1:0]       abs_x, abs_y, maj, mnr;
    logic signed [TERM_W-1:0] two_mnr, two_maj;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign w_eff  = eff_dim(r_grid_w);
    assign h_eff  = eff_dim(r_grid_h);
    assign ram_we = accept && !i_kind && ({1'b0, i_cell_x} < (COORD_W + 1)'(GRID_DIM))
                    && ({1'b0, i_cell_y} < (COORD_W + 1)'(GRID_DIM));

    grc_ram #(
        .WIDTH(1),
        .DEPTH(GRID_DIM * GRID_DIM)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_cell_cost == r_lethal),
        .o_rdata(ram_rdata)
    );

    grc_step u_step (
        .i_cur   (r_walk),
        .i_geom  (r_geom),
        .i_w     (w_eff),
        .i_h     (h_eff),
        .o_next  (step_next),
        .o_inside(step_inside)
    );

    always_comb begin
        unique case (r_state)
            S_FETCH: ram_addr = {r_walk.y[COORD_W-1:0], r_walk.x[COORD_W-1:0]};
            S_WALK:  ram_addr = {step_next.y[COORD_W-1:0], step_next.x[COORD_W-1:0]};
            default: ram_addr = {i_cell_y, i_cell_x};
        endcase
    end

    always_comb begin
        dx      = {i_target_x[POS_W-1], i_target_x} - {i_start_x[POS_W-1], i_start_x};
        dy      = {i_target_y[POS_W-1], i_target_y} - {i_start_y[POS_W-1], i_start_y};
        abs_x   = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
        abs_y   = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
        maj     = (abs_x >= abs_y) ? abs_x : abs_y;
        mnr     = (abs_x >= abs_y) ? abs_y : abs_x;
        two_mnr = $signed({2'b00, mnr, 1'b0});
        two_maj = $signed({2'b00, maj, 1'b0});
    end

    always_comb begin
        n_state  = r_state;
        n_walk   = r_walk;
        n_geom   = r_geom;
        n_single = r_single;
        n_seen   = r_seen;
        n_valid  = 1'b0;
        n_out_x  = r_out_x;
        n_out_y  = r_out_y;
        n_class  = r_class;
        n_last   = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_kind) begin
                    n_seen         = 1'b0;
                    n_walk.x       = i_start_x;
                    n_walk.y       = i_start_y;
                    n_walk.f       = two_mnr - TERM_W'(maj);
                    n_geom.d1      = two_mnr;
                    n_geom.d2      = two_mnr - two_maj;
                    n_geom.ix      = (dx == '0) ? '0 : (dx[POS_W] ? '1 : POS_W'(1));
                    n_geom.iy      = (dy == '0) ? '0 : (dy[POS_W] ? '1 : POS_W'(1));
                    n_geom.x_major = (abs_x >= abs_y);
                    n_single       = (abs_x == '0) && (abs_y == '0);
                    if (inside_grid(i_start_x, i_start_y, w_eff, h_eff)) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                n_valid = 1'b1;
                n_out_x = r_walk.x[COORD_W-1:0];
                n_out_y = r_walk.y[COORD_W-1:0];
                n_last  = r_single || !step_inside;
                if (r_seen) begin
                    n_class = CLASS_UNKNOWN;
                end else if (ram_rdata) begin
                    n_class = CLASS_OCCUPIED;
                    n_seen  = 1'b1;
                end else begin
                    n_class = CLASS_FREE;
                end
                if (r_single) begin
                    n_state = S_IDLE;
                end else begin
                    n_walk = step_next;
                    if (!step_inside) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_walk   <= '0;
            r_seen   <= 1'b0;
            r_valid  <= 1'b0;
            r_single <= 1'b0;
            r_grid_w <= DIM_W'(64);
            r_grid_h <= DIM_W'(64);
            r_lethal <= COST_W'(254);
        end else begin
            r_state  <= n_state;
            r_walk   <= n_walk;
            r_seen   <= n_seen;
            r_valid  <= n_valid;
            r_single <= n_single;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GRID_WIDTH:  r_grid_w <= i_cfg_data[DIM_W-1:0];
                    REG_GRID_HEIGHT: r_grid_h <= i_cfg_data[DIM_W-1:0];
                    REG_LETHAL_COST: r_lethal <= i_cfg_data[COST_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_geom  <= n_geom;
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
        r_class <= n_class;
        r_last  <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_cell_class = r_class;
    assign o_is_last    = r_last;

    `ASSERT_SAME(a_valid_from_walk, i_clk, i_rst_n, o_valid, $past(r_state) == S_WALK)
    `ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_valid && o_is_last, !o_valid)
    `ASSERT_SAME(a_no_load_when_busy, i_clk, i_rst_n, busy, !ram_we)
    `ASSERT_NEXT(a_unknown_after_hit, i_clk, i_rst_n,
                 o_valid && !o_is_last && (o_cell_class != CLASS_FREE),
                 !o_valid || (o_cell_class == CLASS_UNKNOWN))

endmodule

### rtl/grc_ram.sv
// Generic single-port RAM with registered read.
module grc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/grc_step.sv
// Bresenham step unit: advances the walk by one cell and checks the new cell against the grid.
module grc_step import grc_pkg::*; (
    input  t_walk            i_cur,
    input  t_geom            i_geom,
    input  logic [DIM_W-1:0] i_w,
    input  logic [DIM_W-1:0] i_h,
    output t_walk            o_next,
    output logic             o_inside
);

    logic f_neg;

    always_comb begin
        f_neg    = i_cur.f[TERM_W-1];
        o_next.f = f_neg ? (i_cur.f + i_geom.d1) : (i_cur.f + i_geom.d2);
        if (i_geom.x_major) begin
            o_next.x = i_cur.x + i_geom.ix;
            o_next.y = f_neg ? i_cur.y : (i_cur.y + i_geom.iy);
        end else begin
            o_next.y = i_cur.y + i_geom.iy;
            o_next.x = f_neg ? i_cur.x : (i_cur.x + i_geom.ix);
        end
        o_inside = inside_grid(o_next.x, o_next.y, i_w, i_h);
    end

endmodule

### bench/testbench.sv
// Self-checking testbench for the grid ray-cast classifier: map loads, ray traces and settings.
module testbench;
    import grc_pkg::*;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_TRACE = 1'b1
    } t_item_kind;

    typedef struct packed {
        t_item_kind          kind;
        logic [COORD_W-1:0]  cell_x;
        logic [COORD_W-1:0]  cell_y;
        logic [COST_W-1:0]   cell_cost;
        logic [POS_W-1:0]    start_x;
        logic [POS_W-1:0]    start_y;
        logic [POS_W-1:0]    target_x;
        logic [POS_W-1:0]    target_y;
    } t_grid_item;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [1:0]         cls;
        logic               last;
    } t_cell_report;

    localparam int NUM_PHASES       = 8;
    localparam int RANDOM_PER_PHASE = 8;
    localparam int FILL_DIM         = 8;
    localparam int STALL_LIMIT      = 2000;

    // Every configured grid lies inside the square fill block, row zero or column zero.
    int phase_width[NUM_PHASES]  = '{8, 127, 0, 1, 64, 1, 64, 5};
    int phase_height[NUM_PHASES] = '{8, 1, 64, 127, 1, 64, 0, 7};
    int phase_lethal[NUM_PHASES] = '{254, 254, 255, 0, 254, 100, 7, 254};
    int phase_idle[NUM_PHASES]   = '{0, 46, 0, 23, 46, 0, 23, 46};

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_cfg_we = 1'b0;
    logic [IDX_W-1:0]        i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_kind = 1'b0;
    logic [COORD_W-1:0]      i_cell_x = '0;
    logic [COORD_W-1:0]      i_cell_y = '0;
    logic [COST_W-1:0]       i_cell_cost = '0;
    logic signed [POS_W-1:0] i_start_x = '0;
    logic signed [POS_W-1:0] i_start_y = '0;
    logic signed [POS_W-1:0] i_target_x = '0;
    logic signed [POS_W-1:0] i_target_y = '0;
    logic                    o_valid;
    logic [COORD_W-1:0]      o_out_x;
    logic [COORD_W-1:0]      o_out_y;
    logic [1:0]              o_cell_class;
    logic                    o_is_last;

    t_grid_item   pending_items[$];
    t_grid_item   current_item;
    t_cell_report cell_reports[$];
    t_cell_report want_cell;
    bit           lethal_cells[0:GRID_DIM*GRID_DIM-1];
    int           cfg_width = 64;
    int           cfg_height = 64;
    int           cfg_lethal = 254;
    int           sender_idle_pct = 0;
    int           mismatches = 0;
    int           stall_cycles = 0;

    grid_ray_cast_classifier_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_cell_cost  (i_cell_cost),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_target_x   (i_target_x),
        .i_target_y   (i_target_y),
        .o_valid      (o_valid),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_cell_class (o_cell_class),
        .o_is_last    (o_is_last)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 20) begin
            $display("ERROR: %s", msg);
        end
    endtask

    function automatic bit in_grid(input int x, input int y, input int w, input int h);
        return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    // Updates the lethal map for a load, or walks the ray and queues the classified cells.
    function automatic void apply_item(input t_grid_item it);
        int w, h, x, y, dx, dy, ix, iy, a, b, maj, mnr, f;
        bit x_major, blocked;
        logic [1:0] cls;
        t_cell_report rep;
        t_cell_report walk[$];
        if (it.kind == KIND_LOAD) begin
            lethal_cells[{it.cell_y, it.cell_x}] = (int'(it.cell_cost) == cfg_lethal);
            return;
        end
        w = (cfg_width > GRID_DIM) ? GRID_DIM : cfg_width;
        h = (cfg_height > GRID_DIM) ? GRID_DIM : cfg_height;
        x = int'($signed(it.start_x));
        y = int'($signed(it.start_y));
        dx = int'($signed(it.target_x)) - x;
        dy = int'($signed(it.target_y)) - y;
        if (!in_grid(x, y, w, h)) begin
            return;
        end
        ix = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
        iy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
        a = (dx < 0) ? -dx : dx;
        b = (dy < 0) ? -dy : dy;
        x_major = (a >= b);
        maj = x_major ? a : b;
        mnr = x_major ? b : a;
        f = 2 * mnr - maj;
        blocked = 1'b0;
        while (in_grid(x, y, w, h) && walk.size() < GRID_DIM) begin
            if (blocked) begin
                cls = CLASS_UNKNOWN;
            end else if (lethal_cells[y * GRID_DIM + x]) begin
                blocked = 1'b1;
                cls = CLASS_OCCUPIED;
            end else begin
                cls = CLASS_FREE;
            end
            rep.x = COORD_W'(x);
            rep.y = COORD_W'(y);
            rep.cls = cls;
            rep.last = 1'b0;
            walk = {walk, rep};
            if (maj == 0) begin
                break;
            end
            if (f < 0) begin
                f += 2 * mnr;
            end else begin
                if (x_major) begin
                    y += iy;
                end else begin
                    x += ix;
                end
                f += 2 * (mnr - maj);
            end
            if (x_major) begin
                x += ix;
            end else begin
                y += iy;
            end
        end
        walk[walk.size() - 1].last = 1'b1;
        cell_reports = {cell_reports, walk};
    endfunction

    function automatic void queue_load(input int x, input int y, input int cost);
        t_grid_item it;
        it.kind = KIND_LOAD;
        it.cell_x = COORD_W'(x);
        it.cell_y = COORD_W'(y);
        it.cell_cost = COST_W'(cost);
        it.start_x = POS_W'($urandom_range(255));
        it.start_y = POS_W'($urandom_range(255));
        it.target_x = POS_W'($urandom_range(255));
        it.target_y = POS_W'($urandom_range(255));
        pending_items = {pending_items, it};
    endfunction

    function automatic void queue_trace(input int sx, input int sy, input int tx, input int ty);
        t_grid_item it;
        it.kind = KIND_TRACE;
        it.cell_x = COORD_W'($urandom_range(63));
        it.cell_y = COORD_W'($urandom_range(63));
        it.cell_cost = COST_W'($urandom_range(255));
        it.start_x = POS_W'(sx);
        it.start_y = POS_W'(sy);
        it.target_x = POS_W'(tx);
        it.target_y = POS_W'(ty);
        pending_items = {pending_items, it};
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        while (!(pending_items.size() == 0 && !start && !busy && cell_reports.size() == 0)) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_item(current_item);
            end
            if (!start || !busy) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    current_item = pending_items.pop_front();
                    start       <= 1'b1;
                    i_kind      <= current_item.kind;
                    i_cell_x    <= current_item.cell_x;
                    i_cell_y    <= current_item.cell_y;
                    i_cell_cost <= current_item.cell_cost;
                    i_start_x   <= current_item.start_x;
                    i_start_y   <= current_item.start_y;
                    i_target_x  <= current_item.target_x;
                    i_target_y  <= current_item.target_y;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (cell_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected cell x=%0d y=%0d class=%0d last=%0d",
                                          o_out_x, o_out_y, o_cell_class, o_is_last));
            end else begin
                want_cell = cell_reports.pop_front();
                if (o_out_x !== want_cell.x || o_out_y !== want_cell.y ||
                    o_cell_class !== want_cell.cls || o_is_last !== want_cell.last) begin
                    report_mismatch($sformatf(
                        "cell got %0d,%0d class %0d last %0d, want %0d,%0d class %0d last %0d",
                        o_out_x, o_out_y, o_cell_class, o_is_last,
                        want_cell.x, want_cell.y, want_cell.cls, want_cell.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("grid_ray_cast_classifier_top test failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int p, k, r, w, h, sx, sy, i;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_GRID_WIDTH;
            i_cfg_data <= CFG_W'(phase_width[p]);
            @(posedge i_clk);
            i_cfg_idx  <= REG_GRID_HEIGHT;
            i_cfg_data <= CFG_W'(phase_height[p]);
            @(posedge i_clk);
            i_cfg_idx  <= REG_LETHAL_COST;
            i_cfg_data <= CFG_W'(phase_lethal[p]);
            @(posedge i_clk);
            i_cfg_we   <= 1'b0;
            @(negedge i_clk);
            cfg_width = phase_width[p];
            cfg_height = phase_height[p];
            cfg_lethal = phase_lethal[p];
            sender_idle_pct = phase_idle[p];
            w = (cfg_width > GRID_DIM) ? GRID_DIM : cfg_width;
            h = (cfg_height > GRID_DIM) ? GRID_DIM : cfg_height;
            if (p == 0) begin
                // Every map cell that any phase can trace is written before the first trace.
                for (sy = 0; sy < FILL_DIM; sy++) begin
                    for (sx = 0; sx < FILL_DIM; sx++) begin
                        queue_load(sx, sy, ($urandom_range(9) == 0) ? cfg_lethal
                                                                    : $urandom_range(255));
                    end
                end
                for (i = FILL_DIM; i < GRID_DIM; i++) begin
                    queue_load(i, 0, ($urandom_range(19) == 0) ? cfg_lethal
                                                               : $urandom_range(255));
                    queue_load(0, i, ($urandom_range(19) == 0) ? cfg_lethal
                                                               : $urandom_range(255));
                end
                queue_load(4, 5, cfg_lethal);
                queue_load(63, 63, 255);
                queue_load(0, 0, 0);
                queue_trace(0, 5, 63, 5);
                queue_trace(0, 0, 63, 63);
                queue_trace(7, 0, 0, 7);
                queue_trace(5, 5, 5, 5);
                queue_trace(-1, 0, 10, 10);
                queue_trace(8, 3, 0, 0);
                queue_trace(-128, -128, 127, 127);
                queue_trace(127, 127, 0, 0);
                queue_trace(3, 4, -128, -128);
                queue_trace(3, 4, 127, -128);
                queue_trace(0, 3, 63, 5);
                queue_trace(3, 0, 5, 63);
                queue_trace(7, 2, 0, 2);
                queue_trace(2, 7, 2, 0);
                queue_trace(4, 4, 5, -128);
                queue_trace(7, 7, 7, 7);
            end
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                r = $urandom_range(99);
                if (r < 25) begin
                    queue_load($urandom_range(63), $urandom_range(63),
                               ($urandom_range(9) == 0) ? cfg_lethal : $urandom_range(255));
                end else if (r < 35 || w == 0 || h == 0) begin
                    queue_trace($urandom_range(255), $urandom_range(255),
                                $urandom_range(255), $urandom_range(255));
                end else begin
                    sx = $urandom_range(w - 1);
                    sy = $urandom_range(h - 1);
                    if (r < 45) begin
                        queue_trace(sx, sy, sx, sy);
                    end else if (r < 75) begin
                        queue_trace(sx, sy, $urandom_range(63), $urandom_range(63));
                    end else begin
                        queue_trace(sx, sy, $urandom_range(255), $urandom_range(255));
                    end
                end
            end
        end
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (cell_reports.size() != 0) begin
            report_mismatch($sformatf("%0d expected cells never reported", cell_reports.size()));
        end
        if (mismatches == 0) begin
            $display("grid_ray_cast_classifier_top test passed");
        end else begin
            $display("grid_ray_cast_classifier_top test failed");
        end
        $finish;
    end

endmodule
